### rtl/pngunf_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and the paeth predictor for the png scanline unfilter
package pngunf_pkg;

	localparam int MAX_LINE_BYTES  = 16384;
	localparam int MAX_PIXEL_BYTES = 8;

	localparam int POS_W  = $clog2(MAX_LINE_BYTES);
	localparam int LEN_W  = 15;
	localparam int STEP_W = 4;
	localparam int SEL_W  = $clog2(MAX_PIXEL_BYTES);
	localparam int CFG_W  = LEN_W;

	typedef logic [0:0] reg_idx_t;
	localparam reg_idx_t REG_BYTES_PER_LINE = 1'b0;
	localparam reg_idx_t REG_FILTER_STEP    = 1'b1;

	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4
	} filt_t;

	function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic signed [10:0] p;
		logic signed [10:0] da;
		logic signed [10:0] db;
		logic signed [10:0] dc;
		logic signed [10:0] pa;
		logic signed [10:0] pb;
		logic signed [10:0] pc;
		p  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
		da = p - $signed({3'b000, a});
		db = p - $signed({3'b000, b});
		dc = p - $signed({3'b000, c});
		pa = da[10] ? -da : da;
		pb = db[10] ? -db : db;
		pc = dc[10] ? -dc : dc;
		if (pa <= pb && pa <= pc) begin
			return a;
		end else if (pb <= pc) begin
			return b;
		end else begin
			return c;
		end
	endfunction

endpackage

### rtl/png_scanline_unfilter.sv
`timescale 1ns / 1ps
// png scanline unfilter: filter byte decode, line store and byte reconstruction
// throughput: one byte per cycle unless the output stalls, filter bytes included, limited by the
//   left-neighbour feedback from the result of one byte into the next
// path: a filtered byte enters the input register at its accepting edge and its result is
//   written to the output register as it leaves stage one, which an output stall holds back
// reset clears control, neighbour registers and the output valid; the line store is
//   not cleared and needs no clearing pass
module png_scanline_unfilter
	import pngunf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  reg_idx_t    cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tuser,   // image_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // pixel_byte
	output logic        m_tlast    // row_end
);

	logic [LEN_W-1:0]  bpl_q;
	logic [STEP_W-1:0] step_q;
	logic [LEN_W-1:0]  line_len;
	logic [STEP_W-1:0] step_len;
	logic [SEL_W-1:0]  step_sel;

	logic [POS_W-1:0] pos_q;
	filt_t            kind_q;
	logic             first_row_q;
	logic             awaiting_q;

	logic [7:0] mem [MAX_LINE_BYTES];
	logic [7:0] rd_s1;
	logic       byp_s1;
	logic [7:0] byp_byte_s1;

	logic             s1_valid;
	logic [7:0]       data_s1;
	logic [POS_W-1:0] pos_s1;
	filt_t            kind_s1;
	logic             first_s1;
	logic             left_ok_s1;
	logic             end_s1;

	logic [7:0] left_q  [MAX_PIXEL_BYTES];
	logic [7:0] upl_q   [MAX_PIXEL_BYTES];

	logic       out_valid_s2;
	logic [7:0] out_byte_s2;
	logic       out_last_s2;

	logic             accept;
	logic             data_acc;
	logic             s1_fire;
	logic             at_end;
	logic [LEN_W-1:0] pos_next;
	logic [7:0]       nb_a;
	logic [7:0]       nb_b;
	logic [7:0]       nb_c;
	logic [8:0]       avg_sum;
	logic [7:0]       pred;
	logic [7:0]       result;

	// register clamping
	always_comb begin
		if (bpl_q == '0) begin
			line_len = LEN_W'(1);
		end else if (bpl_q > LEN_W'(MAX_LINE_BYTES)) begin
			line_len = LEN_W'(MAX_LINE_BYTES);
		end else begin
			line_len = bpl_q;
		end
		if (step_q == '0) begin
			step_len = STEP_W'(1);
		end else if (step_q > STEP_W'(MAX_PIXEL_BYTES)) begin
			step_len = STEP_W'(MAX_PIXEL_BYTES);
		end else begin
			step_len = step_q;
		end
	end

	assign step_sel = SEL_W'(step_len - STEP_W'(1));

	assign s1_fire  = s1_valid && (!out_valid_s2 || m_tready);
	assign s_tready = !s1_valid || s1_fire;
	assign accept   = s_tvalid && s_tready;
	assign data_acc = accept && !s_tuser && !awaiting_q;
	assign pos_next = {1'b0, pos_q} + LEN_W'(1);
	assign at_end   = pos_next >= line_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpl_q  <= LEN_W'(1);
			step_q <= STEP_W'(3);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BYTES_PER_LINE: bpl_q  <= cfg_data;
				REG_FILTER_STEP:    step_q <= cfg_data[STEP_W-1:0];
			endcase
		end
	end

	// row control, input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			kind_q      <= FILT_NONE;
			first_row_q <= 1'b1;
			awaiting_q  <= 1'b1;
			s1_valid    <= 1'b0;
		end else begin
			if (s1_fire) begin
				s1_valid <= 1'b0;
			end
			if (accept) begin
				if (s_tuser || awaiting_q) begin
					kind_q     <= (s_tdata > 8'd4) ? FILT_NONE : filt_t'(s_tdata[2:0]);
					awaiting_q <= 1'b0;
					pos_q      <= '0;
					if (s_tuser) begin
						first_row_q <= 1'b1;
					end
				end else begin
					s1_valid <= 1'b1;
					if (at_end) begin
						pos_q       <= '0;
						awaiting_q  <= 1'b1;
						first_row_q <= 1'b0;
					end else begin
						pos_q <= pos_next[POS_W-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (data_acc) begin
			data_s1    <= s_tdata;
			pos_s1     <= pos_q;
			kind_s1    <= kind_q;
			first_s1   <= first_row_q;
			left_ok_s1 <= {{(POS_W-STEP_W){1'b0}}, step_len} <= pos_q;
			end_s1     <= at_end;
		end
	end

	// line store, read ahead at the accepting edge, written as the byte leaves stage one
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			mem[pos_s1] <= result;
		end
		if (data_acc) begin
			rd_s1       <= mem[pos_q];
			byp_s1      <= s1_fire && (pos_s1 == pos_q);
			byp_byte_s1 <= result;
		end
	end

	always_comb begin
		nb_a    = left_ok_s1 ? left_q[step_sel] : 8'd0;
		nb_b    = first_s1 ? 8'd0 : (byp_s1 ? byp_byte_s1 : rd_s1);
		nb_c    = (!first_s1 && left_ok_s1) ? upl_q[step_sel] : 8'd0;
		avg_sum = {1'b0, nb_a} + {1'b0, nb_b};
		unique case (kind_s1)
			FILT_SUB:   pred = nb_a;
			FILT_UP:    pred = nb_b;
			FILT_AVG:   pred = avg_sum[8:1];
			FILT_PAETH: pred = paeth_pick(nb_a, nb_b, nb_c);
			default:    pred = 8'd0;
		endcase
		result = data_s1 + pred;
	end

	// neighbour shift lines, newest first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
				left_q[i] <= 8'd0;
				upl_q[i]  <= 8'd0;
			end
		end else if (s1_fire) begin
			left_q[0] <= result;
			upl_q[0]  <= nb_b;
			for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
				left_q[i] <= left_q[i-1];
				upl_q[i]  <= upl_q[i-1];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (s1_fire) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_byte_s2 <= result;
			out_last_s2 <= end_s1;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = out_byte_s2;
	assign m_tlast  = out_last_s2;

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !s1_fire |=> s1_valid && $stable(pos_s1))
		else $error("stage one word lost while stalled");

	a_fire_fills: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> m_tvalid)
		else $error("stage one word did not reach the output register");

	a_end_waits: assert property (@(posedge clk) disable iff (!arst_n)
		data_acc && at_end |=> awaiting_q && pos_q == '0)
		else $error("row end did not rearm filter byte decode");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tuser |=> first_row_q && !awaiting_q && pos_q == '0)
		else $error("image start did not restart row zero");

endmodule

### test/tb_png_scanline_unfilter.sv
`timescale 1ns / 1ps
// self-checking testbench for png_scanline_unfilter: directed table, long rows, random phases
module tb_png_scanline_unfilter;
	import pngunf_pkg::*;

	typedef struct packed {
		logic [7:0] px;
		logic       row_end;
	} pix_t;

	typedef enum logic [1:0] {ROW_BYTE, ROW_BPL, ROW_STEP} dir_kind_t;
	typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		dir_kind_t        kind;
		logic [CFG_W-1:0] value;
		logic [7:0]       data;
		logic             start;
		logic             typed;
		logic [7:0]       px;
		logic             row_end;
	} dir_row_t;

	localparam int NUM_DIR = 40;
	localparam int NUM_PHASES = 12;
	localparam int PHASE_WORDS = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	reg_idx_t cfg_index = REG_BYTES_PER_LINE;
	logic [CFG_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h00;   // data_byte
	logic s_tuser = 1'b0;          // image_start
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;           // pixel_byte
	logic m_tlast;                 // row_end

	png_scanline_unfilter uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [CFG_W-1:0] bpl_reg = 15'd1;
	logic [3:0] step_reg = 4'd3;
	logic [7:0] line_store [MAX_LINE_BYTES];
	bit store_valid [MAX_LINE_BYTES];
	logic [7:0] recent_px [MAX_PIXEL_BYTES];
	logic [7:0] recent_above [MAX_PIXEL_BYTES];
	int row_pos = 0;
	filt_t cur_filter = FILT_NONE;
	bit first_row = 1'b1;
	bit await_filter = 1'b1;

	pix_t expected_pixels [$];
	int mismatch_count = 0;
	int words_in = 0;
	int words_out = 0;
	int row_ends = 0;
	int image_starts = 0;
	int reg_writes = 0;
	int gap_pct = 0;
	int stall_pct = 0;

	dir_row_t dir_rows [NUM_DIR] = '{
		'{ROW_BYTE, 15'd0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
		'{ROW_BYTE, 15'd0, 8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1},
		'{ROW_BYTE, 15'd0, 8'h01, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_BYTE, 15'd0, 8'h00, 1'b0, 1'b1, 8'h00, 1'b1},
		'{ROW_BPL,  15'd0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_BYTE, 15'd0, 8'h02, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_BYTE, 15'd0, 8'h5A, 1'b0, 1'b1, 8'h5A, 1'b1},
		'{ROW_BPL,  15'd4, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_STEP, 15'd1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_BYTE, 15'd0, 8'h02, 1'b1, 1'b0, 8'h00, 1'b0},
		'{ROW_BYTE, 15'd0, 8'h80, 1'b0, 1'b1, 8'h80, 1'b0},
		'{ROW_BYTE, 15'd0, 8'h7F, 1'b0, 1'b1, 8'h7F, 1'b0},
		'{ROW_BYTE, 15'd0, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0},
		'{ROW_BYTE, 15'd0, 8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1},
		'{ROW_BYTE, 15'd0, 8'h02, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_BYTE, 15'd0, 8'h80, 1'b0, 1'b1, 8'h00, 1'b0},
		'{ROW_BYTE, 15'd0, 8'h01, 1'b0, 1'b1, 8'h80, 1'b0},
		'{ROW_BYTE, 15'd0, 8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0},
		'{ROW_BYTE, 15'd0, 8'h01, 1'b0, 1'b1, 8'h00, 1'b1},
		'{ROW_BYTE, 15'd0, 8'h03, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_BYTE, 15'd0, 8'h10, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_BYTE, 15'd0, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_BYTE, 15'd0, 8'h33, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_BYTE, 15'd0, 8'h01, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_BYTE, 15'd0, 8'h04, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_BYTE, 15'd0, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_BYTE, 15'd0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_BYTE, 15'd0, 8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_BYTE, 15'd0, 8'h7F, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_BYTE, 15'd0, 8'hC8, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_BYTE, 15'd0, 8'h11, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_BYTE, 15'd0, 8'hEE, 1'b0, 1'b0, 8'h00, 1'b0},
		// shrink the line while the row is half done
		'{ROW_BPL,  15'd2, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_BYTE, 15'd0, 8'h22, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_BYTE, 15'd0, 8'h01, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_BYTE, 15'd0, 8'h44, 1'b0, 1'b0, 8'h00, 1'b0},
		// new image while a row is open
		'{ROW_BYTE, 15'd0, 8'h04, 1'b1, 1'b0, 8'h00, 1'b0},
		'{ROW_BYTE, 15'd0, 8'h9C, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_STEP, 15'd15, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
		'{ROW_BYTE, 15'd0, 8'h10, 1'b0, 1'b0, 8'h00, 1'b0}
	};

	function automatic logic [7:0] paeth_choice(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		int est;
		int da;
		int db;
		int dc;
		est = int'(a) + int'(b) - int'(c);
		da = (est > int'(a)) ? est - int'(a) : int'(a) - est;
		db = (est > int'(b)) ? est - int'(b) : int'(b) - est;
		dc = (est > int'(c)) ? est - int'(c) : int'(c) - est;
		if (da <= db && da <= dc) begin
			return a;
		end
		return (db <= dc) ? b : c;
	endfunction

	task automatic unfilter_byte(input logic [7:0] d, input logic st, output bit got,
			output pix_t res);
		int len;
		int stp;
		int p;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
		logic [7:0] x;
		logic [8:0] sum9;
		got = 1'b0;
		res = '0;
		len = (bpl_reg == 0) ? 1 : (int'(bpl_reg) > MAX_LINE_BYTES) ? MAX_LINE_BYTES
			: int'(bpl_reg);
		stp = (step_reg == 0) ? 1 : (int'(step_reg) > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES
			: int'(step_reg);
		if (st) begin
			first_row = 1'b1;
			await_filter = 1'b1;
			row_pos = 0;
		end
		if (await_filter) begin
			cur_filter = (d > 8'd4) ? FILT_NONE : filt_t'(d[2:0]);
			await_filter = 1'b0;
			row_pos = 0;
			return;
		end
		p = row_pos;
		a = (p >= stp) ? recent_px[stp-1] : 8'h00;
		b = first_row ? 8'h00 : line_store[p];
		c = (!first_row && p >= stp) ? recent_above[stp-1] : 8'h00;
		case (cur_filter)
			FILT_SUB: x = d + a;
			FILT_UP: x = d + b;
			FILT_AVG: begin
				sum9 = {1'b0, a} + {1'b0, b};
				x = d + sum9[8:1];
			end
			FILT_PAETH: x = d + paeth_choice(a, b, c);
			default: x = d;
		endcase
		for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
			recent_above[i] = recent_above[i-1];
			recent_px[i] = recent_px[i-1];
		end
		recent_above[0] = b;
		recent_px[0] = x;
		line_store[p] = x;
		store_valid[p] = 1'b1;
		res.px = x;
		res.row_end = (p + 1 >= len);
		if (res.row_end) begin
			row_pos = 0;
			await_filter = 1'b1;
			first_row = 1'b0;
		end else begin
			row_pos = p + 1;
		end
		got = 1'b1;
	endtask

	// called just after a rising edge; returns at the edge that took the word
	task automatic push_byte(input logic [7:0] d, input logic st, input bit typed,
			input pix_t want);
		bit got;
		pix_t res;
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tuser <= st;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		words_in++;
		if (st) begin
			image_starts++;
		end
		unfilter_byte(d, st, got, res);
		if (got) begin
			expected_pixels.push_back(typed ? want : res);
		end
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		s_tvalid <= 1'b0;
		while (expected_pixels.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_BYTES_PER_LINE) begin
			bpl_reg = val;
		end else begin
			step_reg = val[3:0];
		end
		reg_writes++;
	endtask

	task automatic random_word(output logic [7:0] d, output logic st);
		st = 1'b0;
		if (await_filter) begin
			d = ($urandom_range(99) < 85) ? 8'($urandom_range(4)) : 8'($urandom_range(255));
			st = ($urandom_range(99) < 8);
		end else begin
			if ($urandom_range(3) == 0) begin
				d = $urandom_range(1) ? 8'hFF : 8'h00;
			end else begin
				d = 8'($urandom_range(255));
			end
			st = ($urandom_range(99) < 2);
			// never read a line store entry that was not written
			if (!first_row && !store_valid[row_pos]) begin
				st = 1'b1;
			end
		end
	endtask

	task automatic set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin gap_pct = 0; stall_pct = 0; end
			IDLE_SEND: begin gap_pct = 86; stall_pct = 0; end
			IDLE_RECV: begin gap_pct = 0; stall_pct = 86; end
			default: begin gap_pct = 22; stall_pct = 22; end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin : check_out
		pix_t want;
		if (arst_n && m_tvalid && m_tready) begin
			words_out++;
			if (m_tlast) begin
				row_ends++;
			end
			if (expected_pixels.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected word px=%02h row_end=%0b", $time, m_tdata, m_tlast);
			end else begin
				want = expected_pixels.pop_front();
				if (m_tdata !== want.px) begin
					mismatch_count++;
					$display("%0t: pixel_byte expected %02h actual %02h", $time, want.px,
						m_tdata);
				end
				if (m_tlast !== want.row_end) begin
					mismatch_count++;
					$display("%0t: row_end expected %0b actual %0b", $time, want.row_end,
						m_tlast);
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		logic [7:0] d;
		logic st;
		logic [CFG_W-1:0] bpl;
		int r;
		for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
			recent_px[i] = 8'h00;
			recent_above[i] = 8'h00;
		end
		for (int i = 0; i < MAX_LINE_BYTES; i++) begin
			store_valid[i] = 1'b0;
			line_store[i] = 8'h00;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idle(IDLE_NONE);
		for (int i = 0; i < NUM_DIR; i++) begin
			case (dir_rows[i].kind)
				ROW_BPL: write_reg(REG_BYTES_PER_LINE, dir_rows[i].value);
				ROW_STEP: write_reg(REG_FILTER_STEP, dir_rows[i].value);
				default: push_byte(dir_rows[i].data, dir_rows[i].start, dir_rows[i].typed,
					'{px: dir_rows[i].px, row_end: dir_rows[i].row_end});
			endcase
		end

		// a new image with the length saturated, a long row that stays open
		write_reg(REG_BYTES_PER_LINE, 15'h7FFF);
		write_reg(REG_FILTER_STEP, 15'd8);
		push_byte(8'd4, 1'b1, 1'b0, '0);
		for (int i = 0; i < 300; i++) begin
			push_byte(8'($urandom_range(255)), 1'b0, 1'b0, '0);
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			r = $urandom_range(99);
			if (r < 5) begin
				bpl = '0;
			end else if (r < 10) begin
				bpl = 15'($urandom_range(32767, 16385));
			end else if (r < 30) begin
				bpl = 15'($urandom_range(200, 25));
			end else begin
				bpl = 15'($urandom_range(24, 1));
			end
			write_reg(REG_BYTES_PER_LINE, bpl);
			write_reg(REG_FILTER_STEP, (ph == 0) ? 15'd0 : 15'($urandom_range(15)));
			set_idle(idle_mode_t'(ph % 4));
			for (int i = 0; i < PHASE_WORDS; i++) begin
				random_word(d, st);
				push_byte(d, st, 1'b0, '0);
			end
		end

		s_tvalid <= 1'b0;
		while (expected_pixels.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		$display("covered %0d input words and %0d output words, %0d row ends", words_in,
			words_out, row_ends);
		$display("over %0d image starts and %0d register writes", image_starts, reg_writes);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

### sim.f
rtl/pngunf_pkg.sv
rtl/png_scanline_unfilter.sv
test/tb_png_scanline_unfilter.sv
